// ----- hdl/flse_pkg.sv -----
// ----------------------------------------------------------------------------
// flse_pkg: shared types and constants for the log sample encoder.
// Holds representation codes, field widths and the channel payload types.
// ----------------------------------------------------------------------------
package flse_pkg;

  // Representation codes.
  localparam logic [7:0] REP_F32 = 8'd68;
  localparam logic [7:0] REP_I32 = 8'd73;
  localparam logic [7:0] REP_I16 = 8'd79;

  // IEEE-754 field masks and special exponents.
  localparam logic [31:0] MANT_MASK = 32'h007F_FFFF;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [7:0]  EXP_ONE   = 8'd127;
  localparam logic [7:0]  EXP_MAX   = 8'd255;

  // Input item.
  typedef struct packed {
    logic [31:0] sample_bits;
    logic [7:0]  rep_code;
    logic        last_sample;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [31:0] code_word;
    logic [2:0]  byte_count;
    logic        saturated;
    logic        last_out;
  } out_item_t;

endpackage

// ----- hdl/flse_in_if.sv -----
// ----------------------------------------------------------------------------
// flse_in_if: sample input channel.
// Valid/ready handshake carrying one sample word per transfer.
// ----------------------------------------------------------------------------
interface flse_in_if;
  logic               valid;
  logic               ready;
  flse_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/flse_out_if.sv -----
// ----------------------------------------------------------------------------
// flse_out_if: encoded result channel.
// Valid/ready handshake carrying one encoded word per transfer.
// ----------------------------------------------------------------------------
interface flse_out_if;
  logic                valid;
  logic                ready;
  flse_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/flse_convert.sv -----
// ----------------------------------------------------------------------------
// flse_convert: combinational sample conversion.
// Turns one single-precision pattern into the coded bytes for a given code.
// ----------------------------------------------------------------------------
module flse_convert (
  input  flse_pkg::in_item_t  item,
  output flse_pkg::out_item_t result
);

  logic [7:0]  e;
  logic        neg;
  logic [23:0] sig;
  logic [22:0] f;
  logic        tiny;
  logic        over;
  logic [31:0] mag;
  logic [4:0]  sh;
  logic [31:0] f68;
  logic        f68_sat;
  logic [32:0] lim;
  logic [31:0] ival;
  logic        isat;
  logic [32:0] mag_x;

  always_comb begin
    e    = item.sample_bits[30:23];
    neg  = item.sample_bits[31];
    sig  = {1'b1, item.sample_bits[22:0]};
    f    = sig[23:1];

    // Code 68 log float.
    f68_sat = 1'b0;
    if (e == 8'd0) begin
      f68 = '0;
    end else if (e >= 8'd254) begin
      f68_sat = 1'b1;
      f68 = neg ? (flse_pkg::SIGN_BIT | 32'd1) : ~flse_pkg::SIGN_BIT;
    end else if (!neg) begin
      f68 = {1'b0, 8'(e + 8'd2), f};
    end else begin
      f68 = flse_pkg::SIGN_BIT | {1'b0, 8'(8'd253 - e), 23'(23'd0 - f)};
    end

    // Truncated integer magnitude; exponents 127..158 fit a 32-bit shift.
    tiny = (e < flse_pkg::EXP_ONE);
    over = (e == flse_pkg::EXP_MAX) || (e >= 8'd159);
    sh   = 5'(e - flse_pkg::EXP_ONE);
    if (tiny || over) begin
      mag = '0;
    end else if (e < 8'd150) begin
      mag = {8'd0, sig} >> 5'(8'd150 - e);
    end else begin
      mag = {8'd0, sig} << 5'(sh - 5'd23);
    end
    mag_x = {1'b0, mag};

    // Limit for the selected width, then clamp and negate.
    case (item.rep_code)
      flse_pkg::REP_I32: lim = 33'h1_0000_0000 >> 1;
      flse_pkg::REP_I16: lim = 33'd32768;
      default:           lim = 33'd128;
    endcase
    isat = 1'b0;
    if (!neg) begin
      if (over || mag_x > lim - 33'd1) begin
        mag_x = lim - 33'd1;
        isat = 1'b1;
      end
      ival = mag_x[31:0];
    end else begin
      if (over || mag_x > lim) begin
        mag_x = lim;
        isat = 1'b1;
      end
      ival = 32'(33'd0 - mag_x);
    end

    // Select code word and count.
    result.last_out = item.last_sample;
    case (item.rep_code)
      flse_pkg::REP_F32: begin
        result.code_word  = f68;
        result.byte_count = 3'd4;
        result.saturated  = f68_sat;
      end
      flse_pkg::REP_I32: begin
        result.code_word  = ival;
        result.byte_count = 3'd4;
        result.saturated  = isat;
      end
      flse_pkg::REP_I16: begin
        result.code_word  = {ival[15:0], 16'd0};
        result.byte_count = 3'd2;
        result.saturated  = isat;
      end
      default: begin
        result.code_word  = {ival[7:0], 24'd0};
        result.byte_count = 3'd1;
        result.saturated  = isat;
      end
    endcase
  end

endmodule

// ----- hdl/float_to_log_sample_encoder.sv -----
// ----------------------------------------------------------------------------
// float_to_log_sample_encoder: single-precision to log-format sample encoder.
// Registers each sample, converts it in one pass and holds the result word.
//
//   channel  dir  contents
//   in_ch    in   sample_bits, rep_code, last_sample
//   out_ch   out  code_word, byte_count, saturated, last_out
//
// A word accepted at the input is held in the input register, converted,
// and loaded into the result register when the result register is empty
// or being drained; a stalled output holds it in the input register.
// Throughput is one sample per cycle (single conversion pass) unless stalled.
// Reset empties both the input and result registers.
// A stalled output holds its word; the pipeline advances only where it can.
// ----------------------------------------------------------------------------
module float_to_log_sample_encoder (
  input logic       clk,
  input logic       rst,
  flse_in_if.sink   in_ch,
  flse_out_if.source out_ch
);

  flse_pkg::in_item_t  in_reg;
  logic                in_vld;
  flse_pkg::out_item_t conv;
  flse_pkg::out_item_t out_reg;
  logic                out_vld;
  logic                adv;

  // Stage advances when the result register is empty or being drained.
  assign adv         = !out_vld || out_ch.ready;
  assign in_ch.ready = !in_vld || adv;

  flse_convert u_conv (
    .item   (in_reg),
    .result (conv)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_reg <= in_ch.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
    if (adv && in_vld) begin
      out_reg <= conv;
    end
  end

  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_reg;

endmodule
